>>> sv/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;

  // Hue in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_SIXTY      = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_RED_BASE   = 15'd0;

  // Restoring divider: dividend width, stages, quotient bits per stage
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = DIV_NUM_W / DIV_STAGES;

  // Useful quotient widths: hue sector offset <= 3840, saturation <= 65536
  localparam int HUE_Q_W = 12;
  localparam int SAT_Q_W = SAT_W + 1;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_out;
    logic             hue_undefined;
    logic [SAT_W-1:0] saturation_out;
    logic [CH_W-1:0]  value_out;
  } hsv_t;

  // Per-item side information that rides along with the division
  typedef struct packed {
    logic [HUE_W-1:0] hue_base;
    logic             hue_neg;
    logic             hue_undefined;
    logic             value_zero;
    logic [CH_W-1:0]  value;
  } tag_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] hue_num;
    logic [CH_W-1:0]      hue_den;
    logic [DIV_NUM_W-1:0] sat_num;
    logic [CH_W-1:0]      sat_den;
  } div_in_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] hue_quo;
    logic [CH_W-1:0]      hue_rem;
    logic [DIV_NUM_W-1:0] sat_quo;
  } div_out_t;

endpackage

>>> sv/rgbhsv_front.sv
// First stage: channel max/min, hue sector, numerators and denominators.
`timescale 1ns / 1ps

module rgbhsv_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          pixel_valid,
  input  rgbhsv_pkg::pixel_t            pixel,
  input  logic [rgbhsv_pkg::CH_W-1:0]   threshold,
  output logic                          valid,
  output rgbhsv_pkg::div_in_t           div_in,
  output rgbhsv_pkg::tag_t              tag
);
  import rgbhsv_pkg::*;

  logic [CH_W-1:0]  r, g, b;
  logic [CH_W-1:0]  mx, mn, span;
  logic [CH_W-1:0]  op_a, op_b, diff;
  logic [HUE_W-1:0] base;
  logic             neg;
  logic [19:0]      hue_num;
  div_in_t          div_in_next;
  tag_t             tag_next;

  always_comb begin
    r = pixel.red_in;
    g = pixel.green_in;
    b = pixel.blue_in;

    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;

    // Ties: blue over green over red
    if (mx == b) begin
      base = HUE_BLUE_BASE;
      op_a = r;
      op_b = g;
    end else if (mx == g) begin
      base = HUE_GREEN_BASE;
      op_a = b;
      op_b = r;
    end else if (g >= b) begin
      base = HUE_RED_BASE;
      op_a = g;
      op_b = b;
    end else begin
      // wrap the negative red hue into the top of the circle
      base = HUE_FULL;
      op_a = g;
      op_b = b;
    end
    neg  = op_a < op_b;
    diff = neg ? op_b - op_a : op_a - op_b;

    // 3840 * diff = 4096 * diff - 256 * diff
    hue_num = {diff, 12'd0} - {4'd0, diff, 8'd0};

    div_in_next.hue_num = DIV_NUM_W'(hue_num);
    div_in_next.hue_den = span;
    div_in_next.sat_num = {span, 16'd0};
    div_in_next.sat_den = mx;

    tag_next.hue_base      = base;
    tag_next.hue_neg       = neg;
    tag_next.hue_undefined = (span == '0) || (span < threshold);
    tag_next.value_zero    = (mx == '0);
    tag_next.value         = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_in <= div_in_next;
      tag    <= tag_next;
    end
  end

endmodule

>>> sv/rgbhsv_div.sv
// Pipelined restoring divider, two lanes (hue and saturation), tag carried along.
`timescale 1ns / 1ps

module rgbhsv_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  rgbhsv_pkg::div_in_t  in_data,
  input  rgbhsv_pkg::tag_t     in_tag,
  output logic                 out_valid,
  output rgbhsv_pkg::div_out_t out_data,
  output rgbhsv_pkg::tag_t     out_tag
);
  import rgbhsv_pkg::*;

  logic                 valid [DIV_STAGES+1];
  tag_t                 tag   [DIV_STAGES+1];
  logic [CH_W-1:0]      h_rem [DIV_STAGES+1];
  logic [DIV_NUM_W-1:0] h_nq  [DIV_STAGES+1];
  logic [CH_W-1:0]      h_den [DIV_STAGES+1];
  logic [CH_W-1:0]      s_rem [DIV_STAGES+1];
  logic [DIV_NUM_W-1:0] s_nq  [DIV_STAGES+1];
  logic [CH_W-1:0]      s_den [DIV_STAGES+1];

  assign valid[0] = in_valid;
  assign tag[0]   = in_tag;
  assign h_rem[0] = '0;
  assign h_nq[0]  = in_data.hue_num;
  assign h_den[0] = in_data.hue_den;
  assign s_rem[0] = '0;
  assign s_nq[0]  = in_data.sat_num;
  assign s_den[0] = in_data.sat_den;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [CH_W-1:0]      h_rem_next, s_rem_next;
    logic [DIV_NUM_W-1:0] h_nq_next, s_nq_next;

    // Shift one dividend bit into the remainder per step, quotient bit shifts in below
    always_comb begin
      logic [CH_W:0] ht, st;
      h_rem_next = h_rem[s];
      h_nq_next  = h_nq[s];
      s_rem_next = s_rem[s];
      s_nq_next  = s_nq[s];
      for (int i = 0; i < DIV_STEPS; i++) begin
        ht = {h_rem_next, h_nq_next[DIV_NUM_W-1]};
        if (ht >= {1'b0, h_den[s]}) begin
          h_rem_next = CH_W'(ht - {1'b0, h_den[s]});
          h_nq_next  = {h_nq_next[DIV_NUM_W-2:0], 1'b1};
        end else begin
          h_rem_next = ht[CH_W-1:0];
          h_nq_next  = {h_nq_next[DIV_NUM_W-2:0], 1'b0};
        end
        st = {s_rem_next, s_nq_next[DIV_NUM_W-1]};
        if (st >= {1'b0, s_den[s]}) begin
          s_rem_next = CH_W'(st - {1'b0, s_den[s]});
          s_nq_next  = {s_nq_next[DIV_NUM_W-2:0], 1'b1};
        end else begin
          s_rem_next = st[CH_W-1:0];
          s_nq_next  = {s_nq_next[DIV_NUM_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else if (en) begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[s+1]   <= tag[s];
        h_rem[s+1] <= h_rem_next;
        h_nq[s+1]  <= h_nq_next;
        h_den[s+1] <= h_den[s];
        s_rem[s+1] <= s_rem_next;
        s_nq[s+1]  <= s_nq_next;
        s_den[s+1] <= s_den[s];
      end
    end
  end

  assign out_valid        = valid[DIV_STAGES];
  assign out_tag          = tag[DIV_STAGES];
  assign out_data.hue_quo = h_nq[DIV_STAGES];
  assign out_data.hue_rem = h_rem[DIV_STAGES];
  assign out_data.sat_quo = s_nq[DIV_STAGES];

endmodule

>>> sv/rgbhsv_back.sv
// Final stage: hue offset and wrap, saturation clamp, output register and skid entry.
`timescale 1ns / 1ps

module rgbhsv_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  rgbhsv_pkg::div_out_t in_data,
  input  rgbhsv_pkg::tag_t     in_tag,
  output logic                 en,
  output logic                 hsv_valid,
  input  logic                 hsv_stall,
  output rgbhsv_pkg::hsv_t     hsv
);
  import rgbhsv_pkg::*;

  logic [HUE_Q_W-1:0] hue_q;
  logic [SAT_Q_W-1:0] sat_q;
  logic               rem_nz;
  hsv_t               result;
  hsv_t               skid_item;
  logic               skid_valid;
  logic               take;

  always_comb begin
    hue_q  = in_data.hue_quo[HUE_Q_W-1:0];
    sat_q  = in_data.sat_quo[SAT_Q_W-1:0];
    rem_nz = in_data.hue_rem != '0;

    if (in_tag.hue_undefined) begin
      result.hue_out = '0;
    end else if (in_tag.hue_neg) begin
      // floor of base minus the exact offset: subtract the ceiling
      result.hue_out = in_tag.hue_base - HUE_W'(hue_q) - HUE_W'(rem_nz);
    end else begin
      result.hue_out = in_tag.hue_base + HUE_W'(hue_q);
    end
    result.hue_undefined = in_tag.hue_undefined;

    if (in_tag.value_zero) begin
      result.saturation_out = '0;
    end else if (sat_q[SAT_Q_W-1]) begin
      result.saturation_out = '1;
    end else begin
      result.saturation_out = sat_q[SAT_W-1:0];
    end
    result.value_out = in_tag.value;
  end

  assign take = hsv_valid && !hsv_stall;
  assign en   = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) skid_valid <= 1'b0;
    end else if (!hsv_valid || take) begin
      hsv_valid <= in_valid;
    end else if (in_valid) begin
      // output stalled: park the arriving item and freeze the pipeline
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) hsv <= skid_item;
    end else if (!hsv_valid || take) begin
      hsv <= result;
    end else begin
      skid_item <= result;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> hsv_valid)
    else $error("skid entry holds an item while the output is empty");
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && hsv_stall |=> skid_valid && $stable(skid_item))
    else $error("skid item lost or changed during stall");
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue_out < HUE_FULL)
    else $error("hue out of range");
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.hue_undefined |-> hsv.hue_out == '0)
    else $error("undefined hue not zero");
`endif

endmodule

>>> sv/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per clock, while pixel_stall is low, into hue
// (1/64 degree), saturation (Q0.16) and value. Throughput is one item per
// cycle while pixel_stall is low; an item's result is registered in one front
// stage, four stages of the restoring divider at six quotient bits each and one
// output register before it shows on hsv. pixel_stall comes from a register: a
// one-entry skid buffer behind the output absorbs one item when hsv_stall is
// asserted, and the whole pipeline holds while that entry is full.
// The threshold register is written through cfg_data whenever cfg_valid is
// high (cfg_ready is always high); write it only while no items are in flight.
module rgb_to_hsv_pixel (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  rgbhsv_pkg::pixel_t          pixel,
  output logic                        hsv_valid,
  input  logic                        hsv_stall,
  output rgbhsv_pkg::hsv_t            hsv,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rgbhsv_pkg::CH_W-1:0] cfg_data
);
  import rgbhsv_pkg::*;

  logic            en;
  logic [CH_W-1:0] threshold;
  logic            front_valid;
  div_in_t         front_data;
  tag_t            front_tag;
  logic            div_valid;
  div_out_t        div_data;
  tag_t            div_tag;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  rgbhsv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .threshold   (threshold),
    .valid       (front_valid),
    .div_in      (front_data),
    .tag         (front_tag)
  );

  rgbhsv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .in_tag    (front_tag),
    .out_valid (div_valid),
    .out_data  (div_data),
    .out_tag   (div_tag)
  );

  rgbhsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .in_tag    (div_tag),
    .en        (en),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv)
  );

endmodule
